>>> rtl/arp_pkg.sv
// ============================================================================
// arp_pkg - shared types and constants for the ARP cache
// Table geometry, queue depth, command and result structures.
// ============================================================================
package arp_pkg;

    // table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = QPTR_W + 1;

    // stream payload widths
    localparam int IN_DATA_W  = 224;
    localparam int OUT_DATA_W = 184;
    localparam int FUNC_W     = 2;

    // item kinds on the input stream
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FRAME  = 2'd2;

    // ARP frame constants
    localparam logic [15:0] MIN_FRAME  = 16'd42;
    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [15:0] OP_REPLY   = 16'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP = 1'b1;
    localparam logic [31:0] TTL_RESET = 32'd60000;

    // table operation decided by the front
    typedef enum logic [1:0] {
        CMD_NOP    = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_INSERT = 2'd2
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
        logic [31:0] now_ms;
        logic        send_reply;
        logic [47:0] eth_src_mac;
    } t_cmd;

    typedef struct packed {
        logic        hit;
        logic [47:0] mac_out;
        logic        send_reply;
        logic [47:0] reply_dst_mac;
        logic [47:0] reply_target_mac;
        logic [31:0] reply_target_ip;
    } t_result;

endpackage

>>> rtl/arp_cache_with_ttl.sv
// ============================================================================
// arp_cache_with_ttl - IPv4 to MAC cache with entry lifetime
// Top level: stream ports, configuration registers, front, queue and back.
// ============================================================================
// A 16-entry ARP cache. Each input item (lookup, insert or received ARP frame)
// gives exactly one result item. The front classifies an item in the cycle it
// is accepted and places it in a two-deep command queue; the back engine then
// takes it from the queue, compares all entries, reads and ages the chosen
// entry, then updates the table and loads the result register, and takes the
// next item only after that, waiting while the output is stalled. Results wait
// in an output register while the front keeps taking items until the queue is
// full. The user must write ttl_ms and local_ip through the configuration port
// only while no item is in flight; the block itself does not enforce this.
module arp_cache_with_ttl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [arp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [31:0]                         i_cfg_data,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // ip_addr[31:0], mac_addr[79:32], target_ip[111:80], arp_opcode[127:112],
    // eth_src_mac[175:128], frame_len[191:176], now_ms[223:192]
    input  logic [arp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // func[1:0]
    input  logic [arp_pkg::FUNC_W-1:0]          s_axis_tuser,
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hit[0], mac_out[48:1], send_reply[49], reply_dst_mac[97:50],
    // reply_target_mac[145:98], reply_target_ip[177:146], zero[183:178]
    output logic [arp_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import arp_pkg::*;

    logic [31:0] r_ttl_ms;
    logic [31:0] r_local_ip;

    logic    w_push;
    t_cmd    w_front_cmd;
    logic    w_full;
    logic    w_pop;
    t_cmd    w_head;
    logic    w_empty;
    t_result w_result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl_ms   <= TTL_RESET;
            r_local_ip <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TTL:      r_ttl_ms   <= i_cfg_data;
                CFG_LOCAL_IP: r_local_ip <= i_cfg_data;
                default:      r_ttl_ms   <= r_ttl_ms;
            endcase
        end
    end

    assign s_axis_tready = !w_full;

    arp_front u_front (
        .i_valid    (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .i_local_ip (r_local_ip),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd)
    );

    arp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_head),
        .o_empty (w_empty)
    );

    arp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ttl_ms (r_ttl_ms),
        .i_empty  (w_empty),
        .i_cmd    (w_head),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    // result packing, lowest field first
    assign m_axis_tdata = {6'b0,
                           w_result.reply_target_ip,
                           w_result.reply_target_mac,
                           w_result.reply_dst_mac,
                           w_result.send_reply,
                           w_result.mac_out,
                           w_result.hit};

endmodule

>>> rtl/arp_front.sv
// ============================================================================
// arp_front - input classifier
// Unpacks an input item, decides the table operation and the reply.
// ============================================================================
module arp_front (
    input  logic                          i_valid,
    input  logic [arp_pkg::FUNC_W-1:0]    i_func,
    input  logic [arp_pkg::IN_DATA_W-1:0] i_data,
    input  logic [31:0]                   i_local_ip,
    output logic                          o_push,
    output arp_pkg::t_cmd                 o_cmd
);
    import arp_pkg::*;

    logic [31:0] w_ip;
    logic [47:0] w_mac;
    logic [31:0] w_tip;
    logic [15:0] w_opc;
    logic [47:0] w_esrc;
    logic [15:0] w_flen;
    logic [31:0] w_now;
    logic        w_frame_ok;

    // field unpacking, lowest bits first
    assign w_ip   = i_data[31:0];
    assign w_mac  = i_data[79:32];
    assign w_tip  = i_data[111:80];
    assign w_opc  = i_data[127:112];
    assign w_esrc = i_data[175:128];
    assign w_flen = i_data[191:176];
    assign w_now  = i_data[223:192];

    assign w_frame_ok = (w_flen >= MIN_FRAME);
    assign o_push     = i_valid;

    // classify
    always_comb begin
        o_cmd             = '0;
        o_cmd.ip_addr     = w_ip;
        o_cmd.mac_addr    = w_mac;
        o_cmd.now_ms      = w_now;
        o_cmd.eth_src_mac = w_esrc;
        o_cmd.op          = CMD_NOP;
        case (i_func)
            FUNC_LOOKUP: begin
                o_cmd.op = CMD_LOOKUP;
            end
            FUNC_INSERT: begin
                o_cmd.op = CMD_INSERT;
            end
            FUNC_FRAME: begin
                if (w_frame_ok && (w_opc == OP_REQUEST)) begin
                    o_cmd.op         = CMD_INSERT;
                    o_cmd.send_reply = (w_tip == i_local_ip);
                end else if (w_frame_ok && (w_opc == OP_REPLY)) begin
                    o_cmd.op = CMD_INSERT;
                end
            end
            default: begin
                o_cmd.op = CMD_NOP;
            end
        endcase
    end

endmodule

>>> rtl/arp_fifo.sv
// ============================================================================
// arp_fifo - command queue
// Short queue of classified commands between front and back.
// ============================================================================
module arp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  arp_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output arp_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import arp_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/arp_back.sv
// ============================================================================
// arp_back - table engine
// Sequencer over the cache table: match, age check, update, result.
// ============================================================================
module arp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [31:0]      i_ttl_ms,
    input  logic             i_empty,
    input  arp_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output arp_pkg::t_result o_result
);
    import arp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_AGE   = 4'b0100,
        ST_WRITE = 4'b1000
    } t_state;

    t_state             r_st;
    t_state             n_st;
    t_cmd               r_cmd;

    // table
    logic [ENTRIES-1:0] r_ent_valid;
    logic [31:0]        r_ent_ip   [ENTRIES];
    logic [47:0]        r_ent_mac  [ENTRIES];
    logic [31:0]        r_ent_time [ENTRIES];

    // scan and age results
    logic               r_any_match;
    logic [IDX_W-1:0]   r_idx;
    logic               r_expired;
    logic [47:0]        r_rd_mac;

    logic [ENTRIES-1:0] w_match;
    logic               w_adv;
    logic               w_hit;
    t_result            r_out;
    logic               r_out_valid;

    function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] vec);
        logic [IDX_W-1:0] res;
        res = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (vec[i]) begin
                res = IDX_W'(i);
            end
        end
        return res;
    endfunction

    // parallel tag compare
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_ent_valid[i] && (r_ent_ip[i] == r_cmd.ip_addr);
        end
    end

    assign o_pop    = r_st[0] && !i_empty;
    assign w_adv    = (r_st == ST_WRITE) && (!r_out_valid || i_ready);
    assign w_hit    = r_any_match && !r_expired;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // sequencer
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (!i_empty) n_st = ST_SCAN;
            ST_SCAN:  n_st = ST_AGE;
            ST_AGE:   n_st = ST_WRITE;
            ST_WRITE: if (w_adv) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // control state, valid bits and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_ent_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_adv) begin
                r_out_valid <= 1'b1;
                if (r_cmd.op == CMD_LOOKUP && r_any_match && r_expired) begin
                    r_ent_valid[r_idx] <= 1'b0;
                end else if (r_cmd.op == CMD_INSERT) begin
                    r_ent_valid[r_idx] <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        // pick the slot: first match, else first free, else slot 0
        if (r_st == ST_SCAN) begin
            r_any_match <= |w_match;
            if (|w_match) begin
                r_idx <= first_set(w_match);
            end else if (|(~r_ent_valid)) begin
                r_idx <= first_set(~r_ent_valid);
            end else begin
                r_idx <= '0;
            end
        end
        // age check with wrapping subtraction
        if (r_st == ST_AGE) begin
            r_rd_mac  <= r_ent_mac[r_idx];
            r_expired <= ((r_cmd.now_ms - r_ent_time[r_idx]) >= i_ttl_ms);
        end
        if (w_adv) begin
            if (r_cmd.op == CMD_INSERT) begin
                r_ent_mac[r_idx]  <= r_cmd.mac_addr;
                r_ent_time[r_idx] <= r_cmd.now_ms;
                if (!r_any_match) begin
                    r_ent_ip[r_idx] <= r_cmd.ip_addr;
                end
            end
            r_out.hit              <= (r_cmd.op == CMD_LOOKUP) && w_hit;
            r_out.mac_out          <= ((r_cmd.op == CMD_LOOKUP) && w_hit) ? r_rd_mac : '0;
            r_out.send_reply       <= r_cmd.send_reply;
            r_out.reply_dst_mac    <= r_cmd.send_reply ? r_cmd.eth_src_mac : '0;
            r_out.reply_target_mac <= r_cmd.send_reply ? r_cmd.mac_addr : '0;
            r_out.reply_target_ip  <= r_cmd.send_reply ? r_cmd.ip_addr : '0;
        end
    end

    // a live match on lookup reports a hit
    a_live_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_cmd.op == CMD_LOOKUP && r_any_match && !r_expired) |=> r_out.hit)
        else $error("live entry did not hit");

    // an insert leaves its slot valid
    a_ins_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_cmd.op == CMD_INSERT) |=> r_ent_valid[$past(r_idx)])
        else $error("inserted slot not valid");

    // hit results never carry a reply
    a_hit_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.hit) |-> !r_out.send_reply)
        else $error("hit and reply together");

    // no command taken while one is in flight
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_st == ST_SCAN))
        else $error("command popped outside idle");

endmodule
